### rtl/core/catmull_rom_tangent_builder_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the tangent builder
// Same-cycle and next-cycle implication checks, empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef CATMULL_ROM_TANGENT_BUILDER_TOP_ASSERT_SVH
`define CATMULL_ROM_TANGENT_BUILDER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define CTB_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tangent builder check failed");
`define CTB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tangent builder check failed");
`else
`define CTB_ASSERT_SAME(label, clk, rst, ante, cons)
`define CTB_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### rtl/core/ctb_pkg.sv
// ----------------------------------------------------------------------------
// ctb_pkg
// Types, codes and arithmetic helpers shared by the tangent builder.
// ----------------------------------------------------------------------------
`default_nettype none
package ctb_pkg;
   localparam int COORD_WIDTH = 32;
   localparam int INDEX_WIDTH = 16;
   localparam int WEIGHT_BITS = 30;
   localparam int ADDR_WIDTH  = 3;
   localparam int DATA_WIDTH  = 32;

   localparam logic [1:0] MODE_LINEAR = 2'd1;
   localparam logic [1:0] MODE_QUAD   = 2'd2;

   localparam logic REG_BEGIN_MODE = 1'b0;
   localparam logic REG_END_MODE   = 1'b1;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   typedef struct packed {
      logic [1:0] begin_mode;
      logic [1:0] end_mode;
   } cfg_type;

   typedef enum logic {OP_SQRT, OP_DIV} op_type;

   typedef struct packed {
      logic   start;
      op_type op;
   } unit_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_sts_type;

   typedef enum logic [4:0] {
      S_IDLE, S_HEAD, S_PREP, S_SHIFT, S_SQ_MUL, S_SQ_ACC,
      S_R1_GO, S_R1_WAIT, S_R2_GO, S_R2_WAIT, S_CHK, S_DV_GO, S_DV_WAIT,
      S_BL_MUL, S_BL_ACC, S_BL_RND, S_MID_OUT, S_TAIL
   } state_type;

   function automatic coord_type sat33(input logic signed [COORD_WIDTH:0] v);
      if (v > $signed({2'b00, {(COORD_WIDTH-1){1'b1}}}))
         return {1'b0, {(COORD_WIDTH-1){1'b1}}};
      if (v < $signed({2'b11, {(COORD_WIDTH-1){1'b0}}}))
         return {1'b1, {(COORD_WIDTH-1){1'b0}}};
      return v[COORD_WIDTH-1:0];
   endfunction

   // divide by 2^sh rounding half away from zero, then saturate
   function automatic coord_type round_sat(input logic signed [63:0] v, input int unsigned sh);
      logic [63:0]        m;
      logic [63:0]        r;
      logic signed [63:0] s;
      m = v[63] ? 64'(-v) : 64'(v);
      r = (m + ((64'd1 << sh) >> 1)) >> sh;
      s = v[63] ? -$signed(r) : $signed(r);
      if (s > 64'sd2147483647)
         return {1'b0, {(COORD_WIDTH-1){1'b1}}};
      if (s < -64'sd2147483648)
         return {1'b1, {(COORD_WIDTH-1){1'b0}}};
      return s[COORD_WIDTH-1:0];
   endfunction

   // 0.5 * (3*(b-a) - (d-c))
   function automatic coord_type quad_rule(input coord_type a, input coord_type b,
                                           input coord_type c, input coord_type d);
      logic signed [63:0] e;
      e = 64'sd3 * (64'(b) - 64'(a)) - (64'(d) - 64'(c));
      return round_sat(e, 1);
   endfunction
endpackage
`default_nettype wire

### rtl/core/ctb_channels.sv
// ----------------------------------------------------------------------------
// ctb channels
// Valid/ready interfaces for key points in and tangents out.
// ----------------------------------------------------------------------------
`default_nettype none
interface ctb_req_if;
   import ctb_pkg::*;
   logic      valid;
   logic      ready;
   coord_type point_x;
   coord_type point_y;
   coord_type point_z;
   logic      last_key;
   modport source (output valid, point_x, point_y, point_z, last_key, input ready);
   modport sink (input valid, point_x, point_y, point_z, last_key, output ready);
endinterface

interface ctb_rsp_if;
   import ctb_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [INDEX_WIDTH-1:0] key_index;
   coord_type              tangent_x;
   coord_type              tangent_y;
   coord_type              tangent_z;
   logic                   final_tangent;
   logic                   status;
   modport source (output valid, key_index, tangent_x, tangent_y, tangent_z,
                   final_tangent, status, input ready);
   modport sink (input valid, key_index, tangent_x, tangent_y, tangent_z,
                 final_tangent, status, output ready);
endinterface
`default_nettype wire

### rtl/core/catmull_rom_tangent_builder_top.sv
// ----------------------------------------------------------------------------
// catmull_rom_tangent_builder_top
// Chord-weighted Catmull-Rom tangents from a stream of 3D key points.
// ----------------------------------------------------------------------------
// Key points enter on req_ch, one per transaction, last_key set on the final
// key of a curve. Each key yields up to three tangents on rsp_ch, in key
// order: the first key's (once enough keys are in), the previous interior
// key's and, with the last key, the last key's own.
// One key is worked on at a time; req_ch.ready is low until all its
// tangents are loaded into the output register. End-rule tangents are
// combinational; an interior tangent is paced by the shared root/divide
// unit (two 32-step square roots, one 31-step division) and the single
// multiplier (six squares, six blend products). A stalled rsp_ch holds the
// output register and the sequencer waits on it; the next key is taken
// while the last tangent still waits. Reset clears the point window, key
// count, rules (stop) and output valid. Rules are written over the APB port
// at 0 (begin) and 4 (end) by the user, only while idle; no check enforces it.
// ----------------------------------------------------------------------------
`default_nettype none
`include "catmull_rom_tangent_builder_top_assert.svh"
module catmull_rom_tangent_builder_top (
   input  wire logic                           clock,
   input  wire logic                           reset,
   ctb_req_if.sink                             req_ch,
   ctb_rsp_if.source                           rsp_ch,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [ctb_pkg::ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [ctb_pkg::DATA_WIDTH-1:0] csr_pwdata,
   output logic      [ctb_pkg::DATA_WIDTH-1:0] csr_prdata,
   output logic                                csr_pready
);
   import ctb_pkg::*;

   localparam logic [INDEX_WIDTH-1:0] INDEX_MAX = '1;

   cfg_type      cfg;
   unit_cmd_type unit_cmd;
   unit_sts_type unit_sts;
   logic [31:0]  unit_result;
   logic [63:0]  unit_radicand;
   logic [32:0]  dsum;

   state_type               state_ff, state_in;
   coord_type               cur_ff [3], cur_in [3];
   coord_type               older_ff [3], older_in [3];
   coord_type               newer_ff [3], newer_in [3];
   logic                    last_ff, last_in;
   logic [INDEX_WIDTH-1:0]  kcnt_ff, kcnt_in;
   logic                    head_sent_ff, head_sent_in;
   logic signed [32:0]      v1_ff [3], v1_in [3];
   logic signed [32:0]      v2_ff [3], v2_in [3];
   logic [1:0]              sh_ff, sh_in;
   logic [2:0]              j_ff, j_in;
   logic signed [64:0]      prod_ff, prod_in;
   logic [63:0]             s1_ff, s1_in;
   logic [63:0]             s2_ff, s2_in;
   logic [31:0]             d1_ff, d1_in;
   logic [31:0]             d2_ff, d2_in;
   logic [30:0]             w_ff, w_in;
   logic signed [63:0]      acc_ff, acc_in;
   coord_type               t_ff [3], t_in [3];
   logic                    o_vld_ff, o_vld_in;
   logic [INDEX_WIDTH-1:0]  o_idx_ff, o_idx_in;
   coord_type               o_t_ff [3], o_t_in [3];
   logic                    o_fin_ff, o_fin_in;
   logic                    o_st_ff, o_st_in;

   logic                    load_ok;
   logic                    need_head, need_mid, k_ge2;
   coord_type               head_t [3], tail_t [3];
   logic                    head_st, tail_st;
   logic signed [32:0]      vsel_sq, vsel_bl;
   logic [32:0]             mag_sq;
   logic [30:0]             magsh, wsel;
   logic signed [32:0]      mul_a;
   logic signed [31:0]      mul_b;
   logic [1:0]              comp;
   logic                    any32, any31;

   ctb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign dsum          = {1'b0, d1_ff} + {1'b0, d2_ff};
   assign unit_radicand = (state_ff == S_R1_GO) ? s1_ff : s2_ff;

   always_comb begin
      unit_cmd.start = (state_ff == S_R1_GO) || (state_ff == S_R2_GO) ||
                       (state_ff == S_DV_GO);
      unit_cmd.op    = (state_ff == S_DV_GO) ? OP_DIV : OP_SQRT;
   end

   ctb_root_div u_root_div (
      .clock    (clock),
      .reset    (reset),
      .cmd      (unit_cmd),
      .radicand (unit_radicand),
      .numer    (d2_ff),
      .divisor  (dsum),
      .sts      (unit_sts),
      .result   (unit_result)
   );

   assign load_ok   = !o_vld_ff || rsp_ch.ready;
   assign k_ge2     = (kcnt_ff >= INDEX_WIDTH'(2));
   assign need_head = (kcnt_ff != '0) && !head_sent_ff &&
                      !((cfg.begin_mode == MODE_QUAD) && (kcnt_ff == INDEX_WIDTH'(1)) &&
                        !last_ff);
   assign need_mid  = k_ge2;

   // end-rule tangents, combinational
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         coord_type a0;
         coord_type a1;
         a0 = (kcnt_ff == INDEX_WIDTH'(1)) ? newer_ff[c] : older_ff[c];
         a1 = (kcnt_ff == INDEX_WIDTH'(1)) ? cur_ff[c] : newer_ff[c];
         if (cfg.begin_mode == MODE_LINEAR)
            head_t[c] = sat33(33'(a1) - 33'(a0));
         else if ((cfg.begin_mode == MODE_QUAD) && k_ge2)
            head_t[c] = quad_rule(older_ff[c], newer_ff[c], newer_ff[c], cur_ff[c]);
         else
            head_t[c] = '0;
         if (kcnt_ff == '0)
            tail_t[c] = '0;
         else if (cfg.end_mode == MODE_LINEAR)
            tail_t[c] = sat33(33'(cur_ff[c]) - 33'(newer_ff[c]));
         else if ((cfg.end_mode == MODE_QUAD) && k_ge2)
            tail_t[c] = quad_rule(newer_ff[c], cur_ff[c], older_ff[c], newer_ff[c]);
         else
            tail_t[c] = '0;
      end
      head_st = (cfg.begin_mode == MODE_QUAD) && !k_ge2;
      if (kcnt_ff == '0)
         tail_st = (cfg.begin_mode == MODE_LINEAR) || (cfg.begin_mode == MODE_QUAD) ||
                   (cfg.end_mode == MODE_LINEAR) || (cfg.end_mode == MODE_QUAD);
      else
         tail_st = (cfg.end_mode == MODE_QUAD) && !k_ge2;
   end

   // shared multiplier operand selection and shift range flags
   always_comb begin
      vsel_sq = (j_ff < 3'd3) ? v1_ff[j_ff[1:0]] : v2_ff[2'(j_ff - 3'd3)];
      mag_sq  = vsel_sq[32] ? 33'(-vsel_sq) : 33'(vsel_sq);
      magsh   = 31'(mag_sq >> sh_ff);
      comp    = j_ff[2:1];
      vsel_bl = j_ff[0] ? v2_ff[comp] : v1_ff[comp];
      wsel    = j_ff[0] ? (31'd1 << WEIGHT_BITS) - w_ff : w_ff;
      if (state_ff == S_BL_MUL) begin
         mul_a = vsel_bl;
         mul_b = $signed({1'b0, wsel});
      end else begin
         mul_a = $signed({2'b00, magsh});
         mul_b = $signed({1'b0, magsh});
      end
      any32 = 1'b0;
      any31 = 1'b0;
      for (int c = 0; c < 3; c++) begin
         logic [32:0] m1;
         logic [32:0] m2;
         m1 = v1_ff[c][32] ? 33'(-v1_ff[c]) : 33'(v1_ff[c]);
         m2 = v2_ff[c][32] ? 33'(-v2_ff[c]) : 33'(v2_ff[c]);
         any32 = any32 | m1[32] | m2[32];
         any31 = any31 | m1[31] | m2[31];
      end
   end

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      older_in     = older_ff;
      newer_in     = newer_ff;
      last_in      = last_ff;
      kcnt_in      = kcnt_ff;
      head_sent_in = head_sent_ff;
      v1_in        = v1_ff;
      v2_in        = v2_ff;
      sh_in        = sh_ff;
      j_in         = j_ff;
      prod_in      = prod_ff;
      s1_in        = s1_ff;
      s2_in        = s2_ff;
      d1_in        = d1_ff;
      d2_in        = d2_ff;
      w_in         = w_ff;
      acc_in       = acc_ff;
      t_in         = t_ff;
      o_idx_in     = o_idx_ff;
      o_t_in       = o_t_ff;
      o_fin_in     = o_fin_ff;
      o_st_in      = o_st_ff;
      o_vld_in     = rsp_ch.ready ? 1'b0 : o_vld_ff;
      req_ch.ready = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               cur_in[0] = req_ch.point_x;
               cur_in[1] = req_ch.point_y;
               cur_in[2] = req_ch.point_z;
               last_in   = req_ch.last_key;
               state_in  = S_HEAD;
            end
         end
         S_HEAD: begin
            if (!need_head || load_ok) begin
               if (need_head) begin
                  o_vld_in = 1'b1;
                  o_idx_in = '0;
                  o_t_in   = head_t;
                  o_fin_in = 1'b0;
                  o_st_in  = head_st;
               end
               state_in = need_mid ? S_PREP : S_TAIL;
            end
         end
         S_PREP: begin
            for (int c = 0; c < 3; c++) begin
               v1_in[c] = 33'(newer_ff[c]) - 33'(older_ff[c]);
               v2_in[c] = 33'(cur_ff[c]) - 33'(newer_ff[c]);
            end
            state_in = S_SHIFT;
         end
         S_SHIFT: begin
            // common shift so every magnitude fits in 31 bits
            sh_in    = any32 ? 2'd2 : (any31 ? 2'd1 : 2'd0);
            j_in     = '0;
            s1_in    = '0;
            s2_in    = '0;
            state_in = S_SQ_MUL;
         end
         S_SQ_MUL: begin
            prod_in  = mul_a * mul_b;
            state_in = S_SQ_ACC;
         end
         S_SQ_ACC: begin
            if (j_ff < 3'd3)
               s1_in = s1_ff + prod_ff[63:0];
            else
               s2_in = s2_ff + prod_ff[63:0];
            if (j_ff == 3'd5) begin
               state_in = S_R1_GO;
            end else begin
               j_in     = j_ff + 3'd1;
               state_in = S_SQ_MUL;
            end
         end
         S_R1_GO: state_in = S_R1_WAIT;
         S_R1_WAIT: begin
            if (unit_sts.done) begin
               d1_in    = unit_result;
               state_in = S_R2_GO;
            end
         end
         S_R2_GO: state_in = S_R2_WAIT;
         S_R2_WAIT: begin
            if (unit_sts.done) begin
               d2_in    = unit_result;
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            // coincident points: zero tangent
            if (dsum == '0) begin
               for (int c = 0; c < 3; c++) t_in[c] = '0;
               state_in = S_MID_OUT;
            end else begin
               state_in = S_DV_GO;
            end
         end
         S_DV_GO: state_in = S_DV_WAIT;
         S_DV_WAIT: begin
            if (unit_sts.done) begin
               w_in     = unit_result[30:0];
               j_in     = '0;
               state_in = S_BL_MUL;
            end
         end
         S_BL_MUL: begin
            prod_in  = mul_a * mul_b;
            state_in = S_BL_ACC;
         end
         S_BL_ACC: begin
            acc_in = j_ff[0] ? acc_ff + prod_ff[63:0] : prod_ff[63:0];
            if (j_ff[0]) begin
               state_in = S_BL_RND;
            end else begin
               j_in     = j_ff + 3'd1;
               state_in = S_BL_MUL;
            end
         end
         S_BL_RND: begin
            t_in[comp] = round_sat(acc_ff, WEIGHT_BITS);
            if (j_ff == 3'd5) begin
               state_in = S_MID_OUT;
            end else begin
               j_in     = j_ff + 3'd1;
               state_in = S_BL_MUL;
            end
         end
         S_MID_OUT: begin
            if (load_ok) begin
               o_vld_in = 1'b1;
               o_idx_in = kcnt_ff - INDEX_WIDTH'(1);
               o_t_in   = t_ff;
               o_fin_in = 1'b0;
               o_st_in  = 1'b0;
               state_in = S_TAIL;
            end
         end
         S_TAIL: begin
            if (!last_ff || load_ok) begin
               if (last_ff) begin
                  o_vld_in = 1'b1;
                  o_idx_in = kcnt_ff;
                  o_t_in   = tail_t;
                  o_fin_in = 1'b1;
                  o_st_in  = tail_st;
               end
               // advance the window and the key count
               older_in = newer_ff;
               newer_in = cur_ff;
               if (last_ff) begin
                  kcnt_in      = '0;
                  head_sent_in = 1'b0;
               end else begin
                  head_sent_in = head_sent_ff || need_head;
                  if (kcnt_ff != INDEX_MAX) kcnt_in = kcnt_ff + INDEX_WIDTH'(1);
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         o_vld_ff     <= 1'b0;
         kcnt_ff      <= '0;
         head_sent_ff <= 1'b0;
         for (int c = 0; c < 3; c++) begin
            older_ff[c] <= '0;
            newer_ff[c] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         o_vld_ff     <= o_vld_in;
         kcnt_ff      <= kcnt_in;
         head_sent_ff <= head_sent_in;
         older_ff     <= older_in;
         newer_ff     <= newer_in;
      end
      cur_ff   <= cur_in;
      last_ff  <= last_in;
      v1_ff    <= v1_in;
      v2_ff    <= v2_in;
      sh_ff    <= sh_in;
      j_ff     <= j_in;
      prod_ff  <= prod_in;
      s1_ff    <= s1_in;
      s2_ff    <= s2_in;
      d1_ff    <= d1_in;
      d2_ff    <= d2_in;
      w_ff     <= w_in;
      acc_ff   <= acc_in;
      t_ff     <= t_in;
      o_idx_ff <= o_idx_in;
      o_t_ff   <= o_t_in;
      o_fin_ff <= o_fin_in;
      o_st_ff  <= o_st_in;
   end

   assign rsp_ch.valid         = o_vld_ff;
   assign rsp_ch.key_index     = o_idx_ff;
   assign rsp_ch.tangent_x     = o_t_ff[0];
   assign rsp_ch.tangent_y     = o_t_ff[1];
   assign rsp_ch.tangent_z     = o_t_ff[2];
   assign rsp_ch.final_tangent = o_fin_ff;
   assign rsp_ch.status        = o_st_ff;

   `CTB_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_ch.valid && req_ch.ready, !req_ch.ready)
   `CTB_ASSERT_SAME(a_start_when_free, clock, reset, unit_cmd.start, !unit_sts.busy)
   `CTB_ASSERT_SAME(a_done_awaited, clock, reset, unit_sts.done, (state_ff == S_R1_WAIT) || (state_ff == S_R2_WAIT) || (state_ff == S_DV_WAIT))
endmodule
`default_nettype wire

### rtl/core/ctb_csr.sv
// ----------------------------------------------------------------------------
// ctb_csr
// APB register file holding the begin and end tangent rules.
// ----------------------------------------------------------------------------
`default_nettype none
module ctb_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [ctb_pkg::ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [ctb_pkg::DATA_WIDTH-1:0] csr_pwdata,
   output logic      [ctb_pkg::DATA_WIDTH-1:0] csr_prdata,
   output logic                                csr_pready,
   output ctb_pkg::cfg_type                    cfg
);
   import ctb_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (csr_paddr[2])
            REG_BEGIN_MODE: cfg_in.begin_mode = csr_pwdata[1:0];
            REG_END_MODE:   cfg_in.end_mode   = csr_pwdata[1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_BEGIN_MODE: csr_prdata = {{(DATA_WIDTH-2){1'b0}}, cfg_ff.begin_mode};
         REG_END_MODE:   csr_prdata = {{(DATA_WIDTH-2){1'b0}}, cfg_ff.end_mode};
         default:        csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;
endmodule
`default_nettype wire

### rtl/core/ctb_root_div.sv
// ----------------------------------------------------------------------------
// ctb_root_div
// Shared compare/subtract unit: integer square root or restoring division.
// ----------------------------------------------------------------------------
`default_nettype none
module ctb_root_div (
   input  wire logic                clock,
   input  wire logic                reset,
   input  ctb_pkg::unit_cmd_type    cmd,
   input  wire logic [63:0]         radicand,
   input  wire logic [31:0]         numer,
   input  wire logic [32:0]         divisor,
   output ctb_pkg::unit_sts_type    sts,
   output logic      [31:0]         result
);
   import ctb_pkg::*;

   logic [34:0] rem_ff, rem_in;
   logic [31:0] acc_ff, acc_in;
   logic [63:0] opnd_ff, opnd_in;
   logic [32:0] div_ff, div_in;
   logic [4:0]  cnt_ff, cnt_in;
   op_type      op_ff, op_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [34:0] rem_sh;
   logic [34:0] trial;
   logic        ge;

   always_comb begin
      if (op_ff == OP_SQRT) begin
         rem_sh = {rem_ff[32:0], opnd_ff[63:62]};
         trial  = {1'b0, acc_ff, 2'b01};
      end else begin
         rem_sh = {rem_ff[33:0], opnd_ff[63]};
         trial  = {2'b00, div_ff};
      end
      ge = (rem_sh >= trial);
   end

   always_comb begin
      rem_in  = rem_ff;
      acc_in  = acc_ff;
      opnd_in = opnd_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      op_in   = op_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (busy_ff) begin
         rem_in  = ge ? rem_sh - trial : rem_sh;
         acc_in  = {acc_ff[30:0], ge};
         opnd_in = (op_ff == OP_SQRT) ? {opnd_ff[61:0], 2'b00} : {opnd_ff[62:0], 1'b0};
         cnt_in  = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (cmd.start) begin
         op_in   = cmd.op;
         busy_in = 1'b1;
         acc_in  = '0;
         div_in  = divisor;
         if (cmd.op == OP_SQRT) begin
            rem_in  = '0;
            opnd_in = radicand;
            cnt_in  = 5'd31;
         end else begin
            // top quotient bits are zero, so start from the upper dividend bits
            rem_in  = {4'b0, numer[31:1]};
            opnd_in = {numer[0], 63'b0};
            cnt_in  = 5'd30;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      acc_ff  <= acc_in;
      opnd_ff <= opnd_in;
      div_ff  <= div_in;
      cnt_ff  <= cnt_in;
      op_ff   <= op_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign result   = acc_ff;
endmodule
`default_nettype wire

### bench/tb_catmull_rom_tangent_builder_top.sv
// ----------------------------------------------------------------------------
// tb_catmull_rom_tangent_builder_top
// Self-checking bench for the chord-weighted Catmull-Rom tangent builder.
// ----------------------------------------------------------------------------
// Key points are streamed as curves of random length under random begin/end
// rule, after a directed table of extremes, short curves and coincident
// points. A bit-accurate tangent predictor builds the expected tangents at
// each accepted key; every tangent out is checked field by field against the
// oldest one. Both channels idle in random bursts; once the receiver holds
// off for a long stretch so the block backs up into its input.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_catmull_rom_tangent_builder_top;
   import ctb_pkg::*;

   localparam logic [1:0] MODE_STOP  = 2'd0;
   localparam logic [1:0] MODE_SPARE = 2'd3;
   localparam logic [ADDR_WIDTH-1:0] ADDR_BEGIN = 3'd0;
   localparam logic [ADDR_WIDTH-1:0] ADDR_END   = 3'd4;
   localparam int RANDOM_ITEMS = 280;
   localparam int SETTLE_CYCLES = 400;
   localparam longint CMAX = 64'sd2147483647;
   localparam longint CMIN = -64'sd2147483648;
   localparam coord_type PMAX = 32'sh7fffffff;
   localparam coord_type PMIN = 32'sh80000000;

   typedef struct packed {
      logic [INDEX_WIDTH-1:0] key;
      coord_type              tx;
      coord_type              ty;
      coord_type              tz;
      logic                   fin;
      logic                   st;
   } tangent_type;

   typedef struct {
      coord_type  x, y, z;
      logic       last;
      logic [1:0] bm, em;
      logic       typed;   // single-key curve, result written out here
      logic       tst;
   } key_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [DATA_WIDTH-1:0] csr_pwdata = '0;
   logic [DATA_WIDTH-1:0] csr_prdata;
   logic csr_pready;

   ctb_req_if req_ch ();
   ctb_rsp_if rsp_ch ();

   catmull_rom_tangent_builder_top i_dut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #1 clock = ~clock;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.point_x = '0;
      req_ch.point_y = '0;
      req_ch.point_z = '0;
      req_ch.last_key = 1'b0;
      rsp_ch.ready = 1'b0;
   end

   // predictor state
   logic [1:0] cur_begin = MODE_STOP, cur_end = MODE_STOP;
   longint older_pt[3], newer_pt[3];
   longint unsigned key_cnt = 0;
   logic head_done = 1'b0;
   tangent_type tangent_q[$];
   int fail_cnt = 0, keys_in = 0, tangents_out = 0, curves_sent = 0;
   logic quiet = 1'b0;
   logic skip_next = 1'b0;  // directed row whose tangent is typed in

   function automatic longint unsigned mag(longint v);
      return v < 0 ? longint'(0) - v : v;
   endfunction

   function automatic longint clamp(longint v);
      if (v > CMAX) return CMAX;
      if (v < CMIN) return CMIN;
      return v;
   endfunction

   function automatic longint round_half(longint v, int sh);
      longint unsigned m;
      m = (mag(v) + (64'd1 << (sh - 1))) >> sh;
      return v < 0 ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint unsigned int_root(longint unsigned x);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic longint quad_end(longint a, longint b, longint c, longint d);
      return clamp(round_half(3 * (b - a) - (d - c), 1));
   endfunction

   task automatic chord_blend(input longint p0[3], input longint p1[3], input longint p2[3],
                              output longint t[3]);
      longint v1[3], v2[3];
      longint unsigned m, s1, s2, d1, d2, a, b;
      longint w, sum;
      int sh;
      m = 0; s1 = 0; s2 = 0; sh = 0;
      for (int i = 0; i < 3; i++) begin
         v1[i] = p1[i] - p0[i];
         v2[i] = p2[i] - p1[i];
         if (mag(v1[i]) > m) m = mag(v1[i]);
         if (mag(v2[i]) > m) m = mag(v2[i]);
      end
      while ((m >> sh) >= (64'd1 << 31)) sh++;
      for (int i = 0; i < 3; i++) begin
         a = mag(v1[i]) >> sh;
         b = mag(v2[i]) >> sh;
         s1 += a * a;
         s2 += b * b;
      end
      d1 = int_root(s1);
      d2 = int_root(s2);
      for (int i = 0; i < 3; i++) t[i] = 0;
      if (d1 + d2 != 0) begin
         w = longint'((d2 << WEIGHT_BITS) / (d1 + d2));
         for (int i = 0; i < 3; i++) begin
            sum = w * v1[i] + ((longint'(1) << WEIGHT_BITS) - w) * v2[i];
            t[i] = clamp(round_half(sum, WEIGHT_BITS));
         end
      end
   endtask

   function automatic tangent_type make_tangent(longint unsigned k, longint t[3], logic f,
                                                logic s);
      tangent_type r;
      r.key = k[INDEX_WIDTH-1:0];
      r.tx = t[0][31:0];
      r.ty = t[1][31:0];
      r.tz = t[2][31:0];
      r.fin = f;
      r.st = s;
      return r;
   endfunction

   // work out the tangents that one accepted key releases
   task automatic predict_key(input coord_type px, input coord_type py, input coord_type pz,
                              input logic last, input logic discard);
      longint p[3], t[3], zero[3], a0[3], a1[3];
      longint unsigned k;
      logic s;
      tangent_type res[$];
      p[0] = px; p[1] = py; p[2] = pz;
      zero = '{0, 0, 0};
      k = key_cnt;
      if (k == 0) begin
         if (last) begin
            s = (cur_begin == MODE_LINEAR || cur_begin == MODE_QUAD ||
                 cur_end == MODE_LINEAR || cur_end == MODE_QUAD);
            res.push_back(make_tangent(0, zero, 1'b1, s));
         end
      end else begin
         if (!head_done && !(cur_begin == MODE_QUAD && k == 1 && !last)) begin
            a0 = (k == 1) ? newer_pt : older_pt;
            a1 = (k == 1) ? p : newer_pt;
            s = 1'b0;
            if (cur_begin == MODE_LINEAR) begin
               for (int i = 0; i < 3; i++) t[i] = clamp(a1[i] - a0[i]);
            end else if (cur_begin == MODE_QUAD && k >= 2) begin
               for (int i = 0; i < 3; i++)
                  t[i] = quad_end(older_pt[i], newer_pt[i], newer_pt[i], p[i]);
            end else begin
               s = (cur_begin == MODE_QUAD);
               t = zero;
            end
            res.push_back(make_tangent(0, t, 1'b0, s));
            head_done = 1'b1;
         end
         if (k >= 2) begin
            chord_blend(older_pt, newer_pt, p, t);
            res.push_back(make_tangent(k - 1, t, 1'b0, 1'b0));
         end
         if (last) begin
            s = 1'b0;
            if (cur_end == MODE_LINEAR) begin
               for (int i = 0; i < 3; i++) t[i] = clamp(p[i] - newer_pt[i]);
            end else if (cur_end == MODE_QUAD && k >= 2) begin
               for (int i = 0; i < 3; i++)
                  t[i] = quad_end(newer_pt[i], p[i], older_pt[i], newer_pt[i]);
            end else begin
               s = (cur_end == MODE_QUAD);
               t = zero;
            end
            res.push_back(make_tangent(k, t, 1'b1, s));
         end
      end
      older_pt = newer_pt;
      newer_pt = p;
      if (last) begin
         key_cnt = 0;
         head_done = 1'b0;
      end else if (key_cnt < (64'd1 << INDEX_WIDTH) - 1) begin
         key_cnt++;
      end
      if (!discard)
         foreach (res[i]) tangent_q.push_back(res[i]);
   endtask

   // accept side: predict on every key transaction
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         keys_in++;
         predict_key(req_ch.point_x, req_ch.point_y, req_ch.point_z, req_ch.last_key,
                     skip_next);
      end
   end

   // result side: compare against the oldest expected tangent
   always @(posedge clock) begin
      tangent_type e;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         tangents_out++;
         if (tangent_q.size() == 0) begin
            $error("unexpected tangent for key %0d", rsp_ch.key_index);
            fail_cnt++;
         end else begin
            e = tangent_q.pop_front();
            if (rsp_ch.key_index !== e.key) begin
               $error("key_index expected %0d actual %0d", e.key, rsp_ch.key_index);
               fail_cnt++;
            end
            if (rsp_ch.tangent_x !== e.tx) begin
               $error("tangent_x expected %0d actual %0d", e.tx, rsp_ch.tangent_x);
               fail_cnt++;
            end
            if (rsp_ch.tangent_y !== e.ty) begin
               $error("tangent_y expected %0d actual %0d", e.ty, rsp_ch.tangent_y);
               fail_cnt++;
            end
            if (rsp_ch.tangent_z !== e.tz) begin
               $error("tangent_z expected %0d actual %0d", e.tz, rsp_ch.tangent_z);
               fail_cnt++;
            end
            if (rsp_ch.final_tangent !== e.fin) begin
               $error("final_tangent expected %0d actual %0d", e.fin, rsp_ch.final_tangent);
               fail_cnt++;
            end
            if (rsp_ch.status !== e.st) begin
               $error("status expected %0d actual %0d", e.st, rsp_ch.status);
               fail_cnt++;
            end
         end
      end
   end

   // receiver: random bursts of back-pressure, one long hold-off
   initial begin
      int n;
      logic held;
      held = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!held && keys_in >= 60) begin
            held = 1'b1;
            rsp_ch.ready <= 1'b0;
            for (int c = 0; c < 3000; c++) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 5);
            rsp_ch.ready <= 1'b0;
            repeat (n - 1) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            n = $urandom_range(1, 8);
            repeat (n - 1) @(posedge clock);
         end
      end
   end

   task automatic apb_access(input logic wr, input logic [ADDR_WIDTH-1:0] addr,
                             input logic [DATA_WIDTH-1:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (!wr && csr_prdata[1:0] !== data[1:0]) begin
         $error("register readback expected %0d actual %0d", data[1:0], csr_prdata[1:0]);
         fail_cnt++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // drain the block, then set both rules and read them back
   task automatic set_rules(input logic [1:0] bm, input logic [1:0] em);
      int guard;
      req_ch.valid <= 1'b0;
      @(posedge clock);
      guard = 0;
      while (tangent_q.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      apb_access(1'b1, ADDR_BEGIN, {30'd0, bm});
      apb_access(1'b1, ADDR_END, {30'd0, em});
      apb_access(1'b0, ADDR_BEGIN, {30'd0, bm});
      apb_access(1'b0, ADDR_END, {30'd0, em});
      cur_begin = bm;
      cur_end = em;
   endtask

   task automatic send_key(input coord_type x, input coord_type y, input coord_type z,
                           input logic last);
      int gap;
      req_ch.valid <= 1'b1;
      req_ch.point_x <= x;
      req_ch.point_y <= y;
      req_ch.point_z <= z;
      req_ch.last_key <= last;
      do @(posedge clock); while (!req_ch.ready);
      if (last) curves_sent++;
      if (!quiet && $urandom_range(0, 2) == 0) begin
         gap = $urandom_range(1, 5);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic coord_type pick_coord(coord_type prev);
      case ($urandom_range(0, 9))
         0:       return PMAX;
         1:       return PMIN;
         2:       return prev;
         3, 4:    return coord_type'($urandom);
         default: return coord_type'($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
      endcase
   endfunction

   key_row_type dir_rows[$];

   function automatic key_row_type row(coord_type x, coord_type y, coord_type z, logic last,
                                       logic [1:0] bm, logic [1:0] em, logic typed, logic tst);
      key_row_type r;
      r.x = x; r.y = y; r.z = z; r.last = last; r.bm = bm; r.em = em;
      r.typed = typed; r.tst = tst;
      return r;
   endfunction

   initial begin
      logic curve_open;
      int len, guard;
      coord_type px, py, pz;
      logic [1:0] bm, em;
      longint zero3[3];
      zero3 = '{0, 0, 0};
      // single-key curves, tangent known at a glance
      dir_rows.push_back(row(0, 0, 0, 1, MODE_STOP, MODE_STOP, 1, 0));
      dir_rows.push_back(row(PMAX, PMIN, 5, 1, MODE_LINEAR, MODE_STOP, 1, 1));
      dir_rows.push_back(row(PMIN, PMAX, -5, 1, MODE_STOP, MODE_QUAD, 1, 1));
      dir_rows.push_back(row(7, 7, 7, 1, MODE_SPARE, MODE_SPARE, 1, 0));
      // two keys under quadratic rules: too few keys at both ends
      dir_rows.push_back(row(100, 200, 300, 0, MODE_QUAD, MODE_QUAD, 0, 0));
      dir_rows.push_back(row(400, -200, 0, 1, MODE_QUAD, MODE_QUAD, 0, 0));
      // linear ends saturating on full-range chords
      dir_rows.push_back(row(PMAX, PMAX, PMAX, 0, MODE_LINEAR, MODE_LINEAR, 0, 0));
      dir_rows.push_back(row(PMIN, PMIN, PMIN, 0, MODE_LINEAR, MODE_LINEAR, 0, 0));
      dir_rows.push_back(row(PMAX, PMIN, PMAX, 0, MODE_LINEAR, MODE_LINEAR, 0, 0));
      dir_rows.push_back(row(PMIN, PMAX, PMIN, 1, MODE_LINEAR, MODE_LINEAR, 0, 0));
      // quadratic ends on extremes
      dir_rows.push_back(row(PMIN, 0, PMAX, 0, MODE_QUAD, MODE_QUAD, 0, 0));
      dir_rows.push_back(row(PMAX, PMAX, PMIN, 0, MODE_QUAD, MODE_QUAD, 0, 0));
      dir_rows.push_back(row(0, PMIN, 0, 0, MODE_QUAD, MODE_QUAD, 0, 0));
      dir_rows.push_back(row(PMAX, 0, PMIN, 1, MODE_QUAD, MODE_QUAD, 0, 0));
      // coincident points
      dir_rows.push_back(row(32'sh10000, 32'sh20000, -3, 0, MODE_STOP, MODE_LINEAR, 0, 0));
      dir_rows.push_back(row(32'sh10000, 32'sh20000, -3, 0, MODE_STOP, MODE_LINEAR, 0, 0));
      dir_rows.push_back(row(32'sh10000, 32'sh20000, -3, 1, MODE_STOP, MODE_LINEAR, 0, 0));
      // spare rule code on a short interior curve
      dir_rows.push_back(row(1, 2, 3, 0, MODE_SPARE, MODE_SPARE, 0, 0));
      dir_rows.push_back(row(32'sh30000, -7, 32'sh8000, 0, MODE_SPARE, MODE_SPARE, 0, 0));
      dir_rows.push_back(row(-9, 32'sh50000, 11, 1, MODE_SPARE, MODE_SPARE, 0, 0));

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      curve_open = 1'b0;
      foreach (dir_rows[i]) begin
         if (!curve_open && (dir_rows[i].bm != cur_begin || dir_rows[i].em != cur_end || i == 0))
            set_rules(dir_rows[i].bm, dir_rows[i].em);
         if (dir_rows[i].typed)
            tangent_q.push_back(make_tangent(0, zero3, 1'b1, dir_rows[i].tst));
         skip_next <= dir_rows[i].typed;
         send_key(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z, dir_rows[i].last);
         curve_open = !dir_rows[i].last;
      end

      // random curves, mostly short, rules changed between some of them
      px = 0; py = 0; pz = 0;
      while (keys_in < dir_rows.size() + RANDOM_ITEMS) begin
         if (keys_in > dir_rows.size() + RANDOM_ITEMS - 40) quiet = 1'b1;
         if ($urandom_range(0, 2) == 0) begin
            bm = 2'($urandom_range(0, 3));
            em = 2'($urandom_range(0, 3));
            set_rules(bm, em);
         end
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : $urandom_range(3, 12);
         for (int k = 0; k < len; k++) begin
            px = pick_coord(px);
            py = pick_coord(py);
            pz = pick_coord(pz);
            send_key(px, py, pz, k == len - 1);
         end
      end
      req_ch.valid <= 1'b0;

      guard = 0;
      while (tangent_q.size() != 0 && guard < 400000) begin
         @(posedge clock);
         guard++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (tangent_q.size() != 0) begin
         $error("%0d expected tangents never arrived", tangent_q.size());
         fail_cnt++;
      end
      $display("%0d keys in %0d curves sent, %0d tangents checked under all end rules",
               keys_in, curves_sent, tangents_out);
      if (fail_cnt == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #4000000;
      $display("Test completed with failures");
      $finish;
   end
endmodule
`default_nettype wire
